// File: sv/mpid_pkg.sv
// Shared constants and types for the modular power / inverse / divide block.
package mpid_pkg;

  localparam int PRIME_BITS = 30;
  localparam logic [PRIME_BITS-1:0] PRIME = 30'd998244353;
  localparam logic [PRIME_BITS-1:0] PRIME_MINUS_TWO = 30'd998244351;
  localparam logic [PRIME_BITS:0] PRIME_X2 = 31'd1996488706;

  // Barrett constant floor(2^60 / PRIME), fits in 31 bits.
  localparam logic [PRIME_BITS:0] BARRETT_MU =
    31'((61'd1 << 60) / 61'(PRIME));

  localparam int EXPONENT_BITS_DEFAULT = 63;

  // Pipeline stages of the modular multiplier, from start to done.
  localparam int MUL_STAGES = 5;

  typedef enum logic [1:0] {
    CMD_POWER   = 2'd0,
    CMD_INVERSE = 2'd1,
    CMD_DIVIDE  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_WAIT_ACC,
    ST_SQ_ISSUE,
    ST_WAIT_SQ
  } state_t;

endpackage

// File: sv/mpid_modmul.sv
// Five-stage Barrett modular multiplier, at most one multiply per stage.
module mpid_modmul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mpid_pkg::PRIME_BITS-1:0] op_x,
  input  logic [mpid_pkg::PRIME_BITS-1:0] op_y,
  output logic                            done,
  output logic [mpid_pkg::PRIME_BITS-1:0] result
);

  localparam int PB = mpid_pkg::PRIME_BITS;

  logic [mpid_pkg::MUL_STAGES-1:0] vld_r, vld_nxt;
  logic [2*PB-1:0]   prod_r;      // x*y, < 2^60
  logic [2*PB+1:0]   q2_r;        // (prod >> 29) * mu
  logic [2*PB:0]     q3p_r;       // quotient estimate times prime
  logic [PB+1:0]     rem_r;       // < 3p
  logic [PB-1:0]     res_r;
  logic [PB+1:0]     rem_nxt;
  logic [PB-1:0]     res_nxt;

  assign vld_nxt = {vld_r[mpid_pkg::MUL_STAGES-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    rem_nxt = prod_r[PB+1:0] - q3p_r[PB+1:0];
    if (rem_r >= (PB+2)'(mpid_pkg::PRIME_X2)) begin
      res_nxt = PB'(rem_r - (PB+2)'(mpid_pkg::PRIME_X2));
    end else if (rem_r >= (PB+2)'(mpid_pkg::PRIME)) begin
      res_nxt = PB'(rem_r - (PB+2)'(mpid_pkg::PRIME));
    end else begin
      res_nxt = PB'(rem_r);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= (2*PB)'(op_x) * (2*PB)'(op_y);
    end
    q2_r  <= (2*PB+2)'(prod_r[2*PB-1:PB-1]) * (2*PB+2)'(mpid_pkg::BARRETT_MU);
    q3p_r <= (2*PB+1)'(q2_r[2*PB+1:PB+1]) * (2*PB+1)'(mpid_pkg::PRIME);
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign done   = vld_r[mpid_pkg::MUL_STAGES-1];
  assign result = res_r;

  // The sequencer never issues while a product is in flight.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (vld_r == '0))
    else $error("modmul started while busy");

endmodule

// File: sv/modular_power_inverse_divide.sv
// Top level: power, Fermat inverse and division modulo 998244353.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------------
//  in      | input     | in_valid/in_ready | command, operand_a, operand_b, exponent
//  out     | output    | out_valid/out_ready | residue
//
// One shared 5-stage Barrett multiplier; the sequencer waits for each multiply to finish.
// A scan costs w multiplies and L - 1 squares, L the exponent's bit length and
// w its set bits (no square after the top bit); zero exponent or unused code: none.
// Inverse/divide scan p-2 (L=30, w=28); a power scans up to a full 63-bit exponent.
// Reset clears the sequencer and the output valid; data registers are not reset.
// in_ready only while idle; a done result stalls the sequencer while out is full.
module modular_power_inverse_divide #(
  parameter int EXPONENT_BITS = mpid_pkg::EXPONENT_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_command,
  input  logic [mpid_pkg::PRIME_BITS-1:0] in_operand_a,
  input  logic [mpid_pkg::PRIME_BITS-1:0] in_operand_b,
  input  logic [EXPONENT_BITS-1:0]        in_exponent,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mpid_pkg::PRIME_BITS-1:0] out_residue
);

  localparam int PB = mpid_pkg::PRIME_BITS;
  // Exponent register must also hold p-2 for the inverse.
  localparam int EW = (EXPONENT_BITS > PB) ? EXPONENT_BITS : PB;

  mpid_pkg::state_t state_r, state_nxt;
  logic [PB-1:0] acc_r, acc_nxt;   // running product
  logic [PB-1:0] sq_r, sq_nxt;     // base^(2^i)
  logic [EW-1:0] e_r, e_nxt;       // remaining exponent bits
  logic          out_valid_r, out_valid_nxt;
  logic [PB-1:0] out_residue_r, out_residue_nxt;

  logic          mul_start;
  logic [PB-1:0] mul_x;
  logic          mul_done;
  logic [PB-1:0] mul_res;
  logic [PB-1:0] a_red, b_red;

  // Operands are below 2p, so one conditional subtract reduces them.
  assign a_red = (in_operand_a >= mpid_pkg::PRIME) ? in_operand_a - mpid_pkg::PRIME
                                                    : in_operand_a;
  assign b_red = (in_operand_b >= mpid_pkg::PRIME) ? in_operand_b - mpid_pkg::PRIME
                                                    : in_operand_b;

  // Multiply acc*sq when the current exponent bit is set, else square.
  assign mul_x = (state_r == mpid_pkg::ST_STEP && e_r[0]) ? acc_r : sq_r;

  mpid_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_x   (mul_x),
    .op_y   (sq_r),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpid_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r         <= acc_nxt;
    sq_r          <= sq_nxt;
    e_r           <= e_nxt;
    out_residue_r <= out_residue_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    acc_nxt         = acc_r;
    sq_nxt          = sq_r;
    e_nxt           = e_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_residue_nxt = out_residue_r;
    mul_start       = 1'b0;
    in_ready        = 1'b0;

    case (state_r)
      mpid_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = mpid_pkg::ST_STEP;
          case (in_command)
            mpid_pkg::CMD_POWER: begin
              acc_nxt = PB'(1);
              sq_nxt  = b_red;
              e_nxt   = EW'(in_exponent);
            end
            mpid_pkg::CMD_INVERSE: begin
              acc_nxt = PB'(1);
              sq_nxt  = a_red;
              e_nxt   = EW'(mpid_pkg::PRIME_MINUS_TWO);
            end
            mpid_pkg::CMD_DIVIDE: begin
              // a * b^(p-2): seed the accumulator with the dividend
              acc_nxt = a_red;
              sq_nxt  = b_red;
              e_nxt   = EW'(mpid_pkg::PRIME_MINUS_TWO);
            end
            default: begin
              // unused code: result is zero
              acc_nxt = '0;
              sq_nxt  = '0;
              e_nxt   = '0;
            end
          endcase
        end
      end

      mpid_pkg::ST_STEP: begin
        if (e_r == '0) begin
          // done; deliver once the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_nxt   = 1'b1;
            out_residue_nxt = acc_r;
            state_nxt       = mpid_pkg::ST_IDLE;
          end
        end else if (e_r[0]) begin
          mul_start = 1'b1;
          state_nxt = mpid_pkg::ST_WAIT_ACC;
        end else begin
          mul_start = 1'b1;
          state_nxt = mpid_pkg::ST_WAIT_SQ;
        end
      end

      mpid_pkg::ST_WAIT_ACC: begin
        if (mul_done) begin
          acc_nxt = mul_res;
          if (e_r[EW-1:1] == '0) begin
            // last bit: skip the trailing square
            e_nxt     = '0;
            state_nxt = mpid_pkg::ST_STEP;
          end else begin
            state_nxt = mpid_pkg::ST_SQ_ISSUE;
          end
        end
      end

      mpid_pkg::ST_SQ_ISSUE: begin
        mul_start = 1'b1;
        state_nxt = mpid_pkg::ST_WAIT_SQ;
      end

      mpid_pkg::ST_WAIT_SQ: begin
        if (mul_done) begin
          sq_nxt    = mul_res;
          e_nxt     = e_r >> 1;
          state_nxt = mpid_pkg::ST_STEP;
        end
      end

      default: begin
        state_nxt = mpid_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;

  // Multiplier results only arrive while the sequencer waits for them.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == mpid_pkg::ST_WAIT_ACC || state_r == mpid_pkg::ST_WAIT_SQ))
    else $error("multiplier result outside a wait state");

  // An accepted transaction always starts the exponent scan.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == mpid_pkg::ST_STEP))
    else $error("accepted transaction did not start");

  // Delivered residues are fully reduced.
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_residue < mpid_pkg::PRIME))
    else $error("residue not reduced");

  // A new result only appears when the scan has consumed the whole exponent.
  a_rise_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_ready)) |->
      ($past(state_r) == mpid_pkg::ST_STEP && $past(e_r) == '0))
    else $error("result issued before exponent exhausted");

endmodule
